/* rtl/shadow_stack_sampling_profiler_assert.svh */
// ----------------------------------------------------------------------------
// shadow stack sampling profiler assertion macros
// concurrent checks on a clock with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef SHADOW_STACK_SAMPLING_PROFILER_ASSERT_SVH
`define SHADOW_STACK_SAMPLING_PROFILER_ASSERT_SVH
`ifndef SYNTHESIS
`define SSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SSP_ASSERT(label, clk, rst_n, prop, msg)
`define SSP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// shared types, codes and constants of the shadow stack sampling profiler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssp_pkg;

    localparam int SSP_STACK_DEPTH = 32;

    localparam int DIV_W   = 64;
    localparam int DEN_W   = 48;
    localparam int DIV_CW  = $clog2(DIV_W + 1);

    // command codes
    localparam logic [2:0] CMD_ENTER = 3'd0;
    localparam logic [2:0] CMD_LEAVE = 3'd1;
    localparam logic [2:0] CMD_EXC   = 3'd2;
    localparam logic [2:0] CMD_POINT = 3'd3;
    localparam logic [2:0] CMD_TAIL  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_ZERO_PTR  = 3'd3;
    localparam logic [2:0] ST_ABOVE_TOP = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // register map
    localparam logic REG_SAMPLE_INTERVAL = 1'b0;

    localparam logic [31:0] INTERVAL_RESET = 32'd10000;
    localparam logic [33:0] TERM_CAP       = 34'h3_0000_0000;

    // divide by three: reciprocal for a 32-bit word, thirds of 2^32
    localparam logic [31:0] RECIP_THREE     = 32'hAAAA_AAAB;
    localparam logic [31:0] THIRD_2_32      = 32'h5555_5555;
    localparam logic [31:0] TWO_THIRDS_2_32 = 32'hAAAA_AAAA;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] method_id;
        logic [31:0] target_method;
        logic [31:0] stack_ptr;
        logic [47:0] stamp;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [31:0] rec_method;
        logic [47:0] rec_start;
        logic [2:0]  status;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] method;
        logic [31:0] sp;
        logic [47:0] start;
    } t_frame;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/shadow_stack_sampling_profiler.sv */
// ----------------------------------------------------------------------------
// shadow_stack_sampling_profiler
// shadow call stack with adaptive sampling of frames
// ----------------------------------------------------------------------------
// One event is taken at a time; the input stalls while an event is in work
// until its status beat is loaded. A sample point on a flagged frame makes no
// sample decision. A sample decision that recomputes the quota runs the
// one-bit-per-cycle divider once for the rate term and then divides by three
// with a fold of the high word and a reciprocal multiply. A leave walks the
// stack frame by frame, reading, checking, comparing and popping, with one
// decision per unflagged frame, and every record or status beat waits for the
// output register to be free. Every event ends with exactly one status beat
// with last set. The frame memory needs no clearing: only pushed frames are
// read.
`timescale 1ns / 1ps
module shadow_stack_sampling_profiler #(
    parameter int STACK_DEPTH = ssp_pkg::SSP_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssp_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssp_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ssp_pkg::*;
    `include "shadow_stack_sampling_profiler_assert.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    // sequencer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_ENTER     = 5'd2;
    localparam logic [4:0] S_LV_READ   = 5'd3;
    localparam logic [4:0] S_LV_CHK    = 5'd4;
    localparam logic [4:0] S_LV_CMP    = 5'd5;
    localparam logic [4:0] S_POP       = 5'd6;
    localparam logic [4:0] S_SAMPLE    = 5'd7;
    localparam logic [4:0] S_MUL       = 5'd8;
    localparam logic [4:0] S_DIVA_GO   = 5'd9;
    localparam logic [4:0] S_DIVA_WAIT = 5'd10;
    localparam logic [4:0] S_SUM       = 5'd11;
    localparam logic [4:0] S_D3_FOLD   = 5'd12;
    localparam logic [4:0] S_D3_MUL    = 5'd13;
    localparam logic [4:0] S_SDONE     = 5'd14;
    localparam logic [4:0] S_ENTER_WR  = 5'd15;
    localparam logic [4:0] S_STATUS    = 5'd16;
    localparam logic [4:0] S_LV_END    = 5'd17;
    localparam logic [4:0] S_D3_DONE   = 5'd18;

    // who asked for the sample decision
    localparam logic [1:0] CTX_ENTER = 2'd0;
    localparam logic [1:0] CTX_LEAVE = 2'd1;
    localparam logic [1:0] CTX_POINT = 2'd2;

    // control state
    logic [4:0]       r_state,    n_state;
    logic [CW-1:0]    r_count,    n_count;
    logic [31:0]      r_counter,  n_counter;
    logic [31:0]      r_quota,    n_quota;
    logic [31:0]      r_prev,     n_prev;
    logic [47:0]      r_last,     n_last;
    logic [31:0]      r_interval;
    logic             r_out_valid, n_out_valid;

    // event payload and scratch
    t_in_beat         r_in,       n_in;
    logic [31:0]      r_en_method, n_en_method;
    logic             r_leaving,  n_leaving;
    logic             r_tail,     n_tail;
    logic             r_final,    n_final;
    logic [1:0]       r_ctx,      n_ctx;
    logic             r_sflag,    n_sflag;
    logic [2:0]       r_status,   n_status;
    logic [63:0]      r_prod,     n_prod;
    logic [47:0]      r_delta,    n_delta;
    logic [33:0]      r_term,     n_term;
    logic [34:0]      r_sum,      n_sum;
    logic [32:0]      r_fold,     n_fold;
    logic [STACK_DEPTH-1:0] r_flag, n_flag;
    t_out_beat        r_out,      n_out;

    logic             w_out_free;
    logic [IW-1:0]    w_top;
    logic             w_cfg_wr;
    logic             w_we;
    t_frame           w_wdata;
    t_frame           w_rdata;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [63:0]      w_mul_p;
    logic [31:0]      w_d3_base;
    logic [31:0]      w_d3_low;

    // output register is free when empty or being taken this edge
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_top      = IW'(r_count - 1'b1);

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_INTERVAL);
    assign prdata   = (paddr[2] == REG_SAMPLE_INTERVAL) ? r_interval : 32'd0;

    // ------------------------------------------------------------------
    // divider, shared multiplier and frame memory
    // ------------------------------------------------------------------
    ssp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // counter times interval for the rate term, or the reciprocal of three
    assign w_mul_a = (r_state == S_D3_MUL) ? r_fold[31:0] : r_counter;
    assign w_mul_b = (r_state == S_D3_MUL) ? RECIP_THREE : r_interval;
    assign w_mul_p = 64'(w_mul_a) * 64'(w_mul_b);

    // 2^32 is 1 mod 3: sum/3 = hi*(2^32-1)/3 + (hi + lo)/3
    assign w_d3_base = (r_sum[33] ? TWO_THIRDS_2_32 : 32'd0) |
                       (r_sum[32] ? THIRD_2_32 : 32'd0);
    // folded word is at most 2^32+1 here, a third of that is a third of 2^32
    assign w_d3_low  = r_fold[32] ? THIRD_2_32 : {1'b0, r_prod[63:33]};

    ssp_frame_store #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_top),
        .o_rdata (w_rdata)
    );

    assign w_wdata.method = r_en_method;
    assign w_wdata.sp     = r_in.stack_ptr;
    assign w_wdata.start  = r_in.stamp;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_counter   = r_counter;
        n_quota     = r_quota;
        n_prev      = r_prev;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_in        = r_in;
        n_en_method = r_en_method;
        n_leaving   = r_leaving;
        n_tail      = r_tail;
        n_final     = r_final;
        n_ctx       = r_ctx;
        n_sflag     = r_sflag;
        n_status    = r_status;
        n_prod      = r_prod;
        n_delta     = r_delta;
        n_term      = r_term;
        n_sum       = r_sum;
        n_fold      = r_fold;
        n_flag      = r_flag;
        n_out       = r_out;
        w_we        = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = r_delta;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_leaving   = (r_in.command != CMD_EXC);
                n_tail      = (r_in.command == CMD_TAIL);
                n_final     = 1'b0;
                n_en_method = (r_in.command == CMD_TAIL) ? r_in.target_method
                                                         : r_in.method_id;
                n_status    = ST_OK;
                priority if (r_in.command == CMD_ENTER) begin
                    n_state = S_ENTER;
                end else if (r_in.command == CMD_LEAVE || r_in.command == CMD_EXC ||
                             r_in.command == CMD_TAIL) begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                        n_state  = S_STATUS;
                    end else begin
                        if (r_counter != '1) n_counter = r_counter + 1'b1;
                        if (r_in.stack_ptr == '0) begin
                            n_status = ST_ZERO_PTR;
                            n_state  = S_STATUS;
                        end else begin
                            n_state = S_LV_READ;
                        end
                    end
                end else if (r_in.command == CMD_POINT) begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                        n_state  = S_STATUS;
                    end else begin
                        if (r_counter != '1) n_counter = r_counter + 1'b1;
                        if (!r_flag[w_top]) begin
                            n_ctx   = CTX_POINT;
                            n_state = S_SAMPLE;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end
                end else begin
                    // unknown command: ok, nothing changes
                    n_state = S_STATUS;
                end
            end
            S_ENTER: begin
                if (r_counter != '1) n_counter = r_counter + 1'b1;
                if (r_count >= CW'(STACK_DEPTH)) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_STATUS;
                end else if (r_in.stack_ptr == '0) begin
                    n_status = ST_ZERO_PTR;
                    n_state  = S_STATUS;
                end else begin
                    n_ctx   = CTX_ENTER;
                    n_state = S_SAMPLE;
                end
            end
            S_LV_READ: begin
                // memory read of the top frame lands this edge
                if (r_count == '0) begin
                    n_status = ST_UNDERFLOW;
                    n_state  = S_LV_END;
                end else begin
                    n_state = S_LV_CHK;
                end
            end
            S_LV_CHK: begin
                if (!r_flag[w_top]) begin
                    n_ctx   = CTX_LEAVE;
                    n_state = S_SAMPLE;
                end else begin
                    n_state = S_LV_CMP;
                end
            end
            S_LV_CMP: begin
                priority if (w_rdata.sp > r_in.stack_ptr) begin
                    n_status = ST_ABOVE_TOP;
                    n_state  = S_LV_END;
                end else if (w_rdata.sp < r_in.stack_ptr) begin
                    n_state = S_POP;
                end else if (r_leaving) begin
                    if (w_rdata.method != r_in.method_id) begin
                        n_status = ST_MISMATCH;
                        n_state  = S_LV_END;
                    end else begin
                        n_final = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    n_status = ST_OK;
                    n_state  = S_LV_END;
                end
            end
            S_POP: begin
                // a flagged frame is reported and marks its parent
                if (!r_flag[w_top] || w_out_free) begin
                    if (r_flag[w_top]) begin
                        n_out_valid      = 1'b1;
                        n_out.kind       = KIND_RECORD;
                        n_out.rec_method = w_rdata.method;
                        n_out.rec_start  = w_rdata.start;
                        n_out.status     = ST_OK;
                        n_out.last       = 1'b0;
                        if (w_top != '0) n_flag[w_top - 1'b1] = 1'b1;
                    end
                    n_count = r_count - 1'b1;
                    if (r_final) begin
                        n_status = ST_OK;
                        n_state  = S_LV_END;
                    end else begin
                        n_state = S_LV_READ;
                    end
                end
            end
            S_SAMPLE: begin
                priority if (r_counter < r_quota) begin
                    n_sflag = 1'b0;
                    n_state = S_SDONE;
                end else if (r_interval != '0 && r_last != '0) begin
                    if (r_in.stamp > r_last) begin
                        n_state = S_MUL;
                    end else begin
                        // time stood still or went back: no rate term
                        n_term  = '0;
                        n_state = S_SUM;
                    end
                end else begin
                    n_quota   = '0;
                    n_last    = r_in.stamp;
                    n_counter = '0;
                    n_sflag   = 1'b1;
                    n_state   = S_SDONE;
                end
            end
            S_MUL: begin
                n_prod  = w_mul_p;
                n_delta = r_in.stamp - r_last;
                n_state = S_DIVA_GO;
            end
            S_DIVA_GO: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIVA_WAIT;
            end
            S_DIVA_WAIT: begin
                if (w_div_rsp.done) begin
                    n_term  = (w_div_rsp.quotient > 64'(TERM_CAP)) ? TERM_CAP
                                                                  : w_div_rsp.quotient[33:0];
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_sum   = 35'(r_term) + 35'(r_counter) + 35'(r_prev);
                n_state = S_D3_FOLD;
            end
            S_D3_FOLD: begin
                n_fold  = 33'(r_sum[31:0]) + 33'(r_sum[33:32]);
                n_state = S_D3_MUL;
            end
            S_D3_MUL: begin
                n_prod  = w_mul_p;
                n_state = S_D3_DONE;
            end
            S_D3_DONE: begin
                // a sum of three times 2^32 or more saturates the quota
                priority if (r_sum >= 35'(TERM_CAP)) begin
                    n_quota = '1;
                end else begin
                    n_quota = w_d3_base + w_d3_low;
                end
                n_prev    = r_counter;
                n_last    = r_in.stamp;
                n_counter = '0;
                n_sflag   = 1'b1;
                n_state   = S_SDONE;
            end
            S_SDONE: begin
                unique case (r_ctx)
                    CTX_ENTER: begin
                        n_state = S_ENTER_WR;
                    end
                    CTX_LEAVE: begin
                        n_flag[w_top] = r_sflag;
                        n_state       = S_LV_CMP;
                    end
                    default: begin
                        n_flag[w_top] = r_sflag;
                        n_status      = ST_OK;
                        n_state       = S_STATUS;
                    end
                endcase
            end
            S_ENTER_WR: begin
                w_we                      = 1'b1;
                n_flag[r_count[IW-1:0]]   = r_sflag;
                n_count                   = r_count + 1'b1;
                n_status                  = ST_OK;
                n_state                   = S_STATUS;
            end
            S_LV_END: begin
                // tail call goes on to its enter part only after a clean leave
                if (r_tail && r_status == ST_OK) begin
                    n_state = S_ENTER;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = KIND_STATUS;
                    n_out.rec_method = '0;
                    n_out.rec_start  = '0;
                    n_out.status     = r_status;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_counter   <= 32'd1;
            r_quota     <= 32'd1;
            r_prev      <= 32'd1;
            r_last      <= '0;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_counter   <= n_counter;
            r_quota     <= n_quota;
            r_prev      <= n_prev;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_interval <= pwdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_en_method <= n_en_method;
        r_leaving   <= n_leaving;
        r_tail      <= n_tail;
        r_final     <= n_final;
        r_ctx       <= n_ctx;
        r_sflag     <= n_sflag;
        r_status    <= n_status;
        r_prod      <= n_prod;
        r_delta     <= n_delta;
        r_term      <= n_term;
        r_sum       <= n_sum;
        r_fold      <= n_fold;
        r_flag      <= n_flag;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SSP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SSP_ASSERT(a_last_is_status, i_clk, i_rst_n, !o_out_valid || (o_out_data.kind == o_out_data.last), "last beat must be the status beat")
    `SSP_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_DISPATCH, "accepted event not dispatched")
    `SSP_ASSERT_NEXT(a_status_idle, i_clk, i_rst_n, r_state == S_STATUS && w_out_free, r_state == S_IDLE && o_out_valid, "status beat did not end the event")

endmodule

/* rtl/ssp_divider.sv */
// ----------------------------------------------------------------------------
// ssp_divider
// restoring divider, one quotient bit per cycle, 64 by 48 bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssp_pkg::t_div_req i_req,
    output ssp_pkg::t_div_rsp o_rsp
);
    import ssp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/ssp_frame_store.sv */
// ----------------------------------------------------------------------------
// ssp_frame_store
// frame memory: method, pointer and start stamp, one write and one read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssp_frame_store #(
    parameter int STACK_DEPTH = ssp_pkg::SSP_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_waddr,
    input  ssp_pkg::t_frame                i_wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_raddr,
    output ssp_pkg::t_frame                o_rdata
);
    import ssp_pkg::*;

    t_frame r_mem [STACK_DEPTH];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shadow stack sampling profiler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// events are queued by a stimulus process and driven on the falling edge by a
// driver; each accepted event runs through a local copy of the shadow stack
// and the adaptive skip quota, which queues the record and status beats that
// must come out; a monitor checks every beat against that queue
module tb_top;
    import ssp_pkg::*;

    localparam int DEPTH = SSP_STACK_DEPTH;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_data;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    shadow_stack_sampling_profiler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // queues between stimulus, driver and monitor
    t_in_beat  event_q[$];
    t_out_beat beat_q[$];
    int        errors = 0;
    int        sent = 0;
    longint    cycle = 0;
    bit        took_in = 0;
    bit        hold_go = 0;
    bit        hold_done = 0;
    bit        calm = 0;
    int        hold_cnt = 0;

    // predicted state of the block
    logic [31:0] pr_method[DEPTH];
    logic [31:0] pr_sp[DEPTH];
    logic [47:0] pr_start[DEPTH];
    bit          pr_flag[DEPTH];
    int          pr_depth = 0;
    logic [47:0] pr_last_stamp = '0;
    logic [31:0] pr_prev_quota = 32'd1;
    logic [31:0] pr_quota = 32'd1;
    logic [31:0] pr_skip = 32'd1;
    logic [31:0] pr_interval = INTERVAL_RESET;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    task automatic bump_skip();
        if (pr_skip != 32'hFFFF_FFFF) pr_skip = pr_skip + 1;
    endtask

    // sample decision, updates the quota when a frame gets sampled
    task automatic decide_sample(input logic [47:0] stamp, output bit hit);
        logic [63:0] term, total, q;
        hit = 0;
        if (pr_skip >= pr_quota) begin
            hit = 1;
            if (pr_interval != 0 && pr_last_stamp != 0) begin
                term = '0;
                // time standing still or running backwards gives no rate term
                if (stamp > pr_last_stamp) begin
                    term = (64'(pr_skip) * 64'(pr_interval)) / 64'(stamp - pr_last_stamp);
                    if (term > 64'(TERM_CAP)) term = 64'(TERM_CAP);
                end
                total = term + 64'(pr_skip) + 64'(pr_prev_quota);
                q = total / 3;
                pr_quota = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                pr_prev_quota = pr_skip;
            end else begin
                pr_quota = '0;
            end
            pr_last_stamp = stamp;
            pr_skip = '0;
        end
    endtask

    task automatic pop_frame();
        int i;
        t_out_beat b;
        i = pr_depth - 1;
        if (pr_flag[i]) begin
            if (i > 0) pr_flag[i-1] = 1;
            b = '{kind: KIND_RECORD, rec_method: pr_method[i], rec_start: pr_start[i],
                  status: ST_OK, last: 1'b0};
            beat_q.push_back(b);
        end
        pr_depth--;
    endtask

    task automatic leave_frames(input bit check_method, input logic [31:0] m,
                                input logic [31:0] sp, input logic [47:0] stamp,
                                output logic [2:0] st);
        int i;
        bit hit;
        if (pr_depth == 0) begin
            st = ST_UNDERFLOW;
            return;
        end
        bump_skip();
        if (sp == 0) begin
            st = ST_ZERO_PTR;
            return;
        end
        forever begin
            if (pr_depth == 0) begin
                st = ST_UNDERFLOW;
                return;
            end
            i = pr_depth - 1;
            if (!pr_flag[i]) begin
                decide_sample(stamp, hit);
                pr_flag[i] = hit;
            end
            if (pr_sp[i] > sp) begin
                st = ST_ABOVE_TOP;
                return;
            end
            if (pr_sp[i] < sp) begin
                pop_frame();
            end else begin
                // an exception leave keeps the frame at the equal pointer
                if (check_method) begin
                    if (pr_method[i] != m) begin
                        st = ST_MISMATCH;
                        return;
                    end
                    pop_frame();
                end
                st = ST_OK;
                return;
            end
        end
    endtask

    task automatic enter_frame(input logic [31:0] m, input logic [31:0] sp,
                               input logic [47:0] stamp, output logic [2:0] st);
        bit hit;
        bump_skip();
        if (pr_depth >= DEPTH) begin
            st = ST_OVERFLOW;
        end else if (sp == 0) begin
            st = ST_ZERO_PTR;
        end else begin
            pr_start[pr_depth] = stamp;
            decide_sample(stamp, hit);
            pr_flag[pr_depth] = hit;
            pr_method[pr_depth] = m;
            pr_sp[pr_depth] = sp;
            pr_depth++;
            st = ST_OK;
        end
    endtask

    task automatic predict_event(input t_in_beat e);
        logic [2:0] st;
        bit hit;
        t_out_beat b;
        st = ST_OK;
        case (e.command)
            CMD_ENTER: enter_frame(e.method_id, e.stack_ptr, e.stamp, st);
            CMD_LEAVE: leave_frames(1, e.method_id, e.stack_ptr, e.stamp, st);
            CMD_EXC:   leave_frames(0, e.method_id, e.stack_ptr, e.stamp, st);
            CMD_POINT: begin
                if (pr_depth == 0) begin
                    st = ST_UNDERFLOW;
                end else begin
                    bump_skip();
                    if (!pr_flag[pr_depth-1]) begin
                        decide_sample(e.stamp, hit);
                        pr_flag[pr_depth-1] = hit;
                    end
                end
            end
            CMD_TAIL: begin
                leave_frames(1, e.method_id, e.stack_ptr, e.stamp, st);
                if (st == ST_OK) enter_frame(e.target_method, e.stack_ptr, e.stamp, st);
            end
            default: ;
        endcase
        b = '{kind: KIND_STATUS, rec_method: '0, rec_start: '0, status: st, last: 1'b1};
        beat_q.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // driver: events change on the falling edge, acceptance seen on the rising
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle++;
        took_in = i_rst_n && i_in_valid && !o_in_stall;
        if (took_in) predict_event(i_in_data);
        if (cycle > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // no sender gaps in the quiet phase
    function automatic bit sender_gap();
        if (calm) return 0;
        return $urandom_range(0, 99) < 29;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || took_in)) begin
            if (event_q.size() != 0 && !sender_gap()) begin
                i_in_data = event_q.pop_front();
                i_in_valid = 1'b1;
            end else begin
                i_in_valid = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_cnt = 600;
            hold_done = 1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall = 1'b1;
        end else if (calm) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < 29);
        end
    end

    // monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beat_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: got %h", $time, o_out_data);
            end else begin
                want = beat_q.pop_front();
                if (o_out_data.kind !== want.kind || o_out_data.rec_method !== want.rec_method
                    || o_out_data.rec_start !== want.rec_start
                    || o_out_data.status !== want.status || o_out_data.last !== want.last) begin
                    errors++;
                    $display("%0t beat mismatch: expected kind=%0d method=%h start=%h st=%0d last=%0d",
                             $time, want.kind, want.rec_method, want.rec_start, want.status,
                             want.last);
                    $display("%0t                  actual kind=%0d method=%h start=%h st=%0d last=%0d",
                             $time, o_out_data.kind, o_out_data.rec_method,
                             o_out_data.rec_start, o_out_data.status, o_out_data.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [31:0] gen_sp[$];
    logic [31:0] gen_m[$];
    logic [47:0] now = 48'd1;

    task automatic put(input logic [2:0] c, input logic [31:0] m, input logic [31:0] t,
                       input logic [31:0] sp, input logic [47:0] st);
        t_in_beat e;
        e = '{command: c, method_id: m, target_method: t, stack_ptr: sp, stamp: st};
        event_q.push_back(e);
        sent++;
    endtask

    // wait until the block has drained every pending event
    task automatic drain();
        while (event_q.size() != 0 || i_in_valid || beat_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = a; pwdata = d;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        pr_interval = d;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    function automatic logic [47:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return now;
        if (r < 8) now = now - $urandom_range(1, 2000);
        else now = now + $urandom_range(1, 3000);
        return now;
    endfunction

    task automatic gen_enter();
        logic [31:0] sp, m;
        sp = (gen_sp.size() == 0) ? 32'h8000_0000 : gen_sp[$] - $urandom_range(16, 256);
        m = $urandom;
        put(CMD_ENTER, m, $urandom, sp, next_stamp());
        if (gen_sp.size() < DEPTH) begin
            gen_sp.push_back(sp);
            gen_m.push_back(m);
        end
    endtask

    // queues about n events
    task automatic gen_random(input int n);
        int r, k, goal;
        logic [31:0] m;
        goal = sent + n;
        while (sent < goal) begin
            r = $urandom_range(0, 99);
            if (gen_sp.size() < 3 && $urandom_range(0, 39) == 0) begin
                // dive past the full depth to reach overflow
                repeat (DEPTH + 2 - gen_sp.size()) gen_enter();
            end else if (r < 38 && gen_sp.size() < 24) begin
                gen_enter();
            end else if (r < 63 && gen_sp.size() != 0) begin
                // leave some frame, popping everything above it
                k = (r < 50) ? gen_sp.size() - 1 : $urandom_range(0, gen_sp.size() - 1);
                put(CMD_LEAVE, gen_m[k], $urandom, gen_sp[k], next_stamp());
                while (gen_sp.size() > k) begin
                    void'(gen_sp.pop_back());
                    void'(gen_m.pop_back());
                end
            end else if (r < 72 && gen_sp.size() != 0) begin
                k = $urandom_range(0, gen_sp.size() - 1);
                put(CMD_EXC, $urandom, $urandom, gen_sp[k], next_stamp());
                while (gen_sp.size() > k + 1) begin
                    void'(gen_sp.pop_back());
                    void'(gen_m.pop_back());
                end
            end else if (r < 82) begin
                put(CMD_POINT, $urandom, $urandom, $urandom, next_stamp());
            end else if (r < 90 && gen_sp.size() != 0) begin
                m = $urandom;
                put(CMD_TAIL, gen_m[$], m, gen_sp[$], next_stamp());
                gen_m[$] = m;
            end else begin
                // noise: any command, pointer and stamp
                put(3'($urandom), $urandom, $urandom,
                    ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                    {16'($urandom), 32'($urandom)});
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty-stack cases, extremes, mismatch, above top, tail call
        put(CMD_ENTER, 32'h11, 0, 32'd0, 48'd10);
        put(CMD_LEAVE, 32'h11, 0, 32'd100, 48'd20);
        put(CMD_POINT, 32'h11, 0, 32'd100, 48'd30);
        put(CMD_EXC,   32'h11, 0, 32'd100, 48'd40);
        put(CMD_TAIL,  32'h11, 32'h22, 32'd100, 48'd45);
        put(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        put(CMD_ENTER, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 48'd100);
        put(CMD_ENTER, 32'hA1, 0, 32'd1000, 48'd100);
        put(CMD_ENTER, 32'hA2, 0, 32'd500, 48'd50);
        put(CMD_POINT, 32'hA2, 0, 32'd500, 48'd60);
        put(CMD_LEAVE, 32'hBAD, 0, 32'd500, 48'd70);
        put(CMD_EXC,   32'hBAD, 0, 32'd500, 48'd80);
        put(CMD_LEAVE, 32'hA2, 0, 32'd0, 48'd90);
        put(CMD_LEAVE, 32'hA2, 0, 32'd600, 48'd3000);
        put(CMD_TAIL,  32'hBAD, 32'h1234, 32'd1000, 48'd3100);
        put(CMD_TAIL,  32'hA1, 32'h1234, 32'd1000, 48'd5000);
        put(CMD_LEAVE, 32'h1234, 0, 32'd1000, 48'hFFFF_FFFF_FFFF);
        put(CMD_LEAVE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 48'd200);
        put(CMD_ENTER, 32'h5, 0, 32'd100, 48'd300);
        put(CMD_ENTER, 32'h6, 0, 32'd90, 48'd310);
        put(CMD_EXC,   32'h0, 0, 32'd200, 48'd400);
        drain();

        // every sample taken
        apb_write(3'd0, 32'd0);
        now = 48'd1000;
        gen_random(50);
        drain();

        // smallest nonzero interval, no idling on either side
        apb_write(3'd0, 32'd1);
        calm = 1;
        gen_random(40);
        drain();
        calm = 0;

        // typical interval, receiver held off while events keep coming
        apb_write(3'd0, 32'd10000);
        hold_go = 1;
        gen_random(130);
        drain();

        // widest interval last, the quota may end up very large
        apb_write(3'd0, 32'hFFFF_FFFF);
        gen_random(30);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* shadow_stack_sampling_profiler.f */
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_divider.sv
rtl/ssp_frame_store.sv
rtl/shadow_stack_sampling_profiler.sv
sim/tb_top.sv
